FILE: hdl/ecu_pkg.sv
// Shared types, constants and the overshoot table for the easing curve unit.
// No dependencies; every other file refers to it by scoped names.
package ecu_pkg;

   typedef enum logic [1:0] {
      CURVE_LINEAR   = 2'd0,
      CURVE_EASE_IN  = 2'd1,
      CURVE_EASE_OUT = 2'd2,
      CURVE_SPRING   = 2'd3
   } curve_type;

   // spring position is floor(3*e*2^11/d): 2 integer bits, 11 fraction bits
   localparam int POS_WIDTH   = 13;
   localparam int DIV_STEPS   = POS_WIDTH;
   // accept edge to the edge that takes the result
   localparam int RSP_LATENCY = DIV_STEPS + 4;

   localparam int PROG_WIDTH = 9;
   localparam logic [PROG_WIDTH-1:0] PROG_DONE = 9'd256;
   localparam logic [PROG_WIDTH-1:0] PROG_MAX  = 9'd282;

   // floor(x/3) = (x*683)>>11 for x < 2048
   localparam logic [9:0] RECIP3       = 10'd683;
   localparam int         RECIP3_SHIFT = 11;

   typedef struct packed {
      curve_type curve;
      logic      zero;
      logic      done;
   } side_type;

   function automatic logic [PROG_WIDTH-1:0] overshoot(input logic [4:0] idx);
      logic [PROG_WIDTH-1:0] v;
      case (idx)
         5'd0:    v = 9'd0;
         5'd1:    v = 9'd47;
         5'd2:    v = 9'd89;
         5'd3:    v = 9'd126;
         5'd4:    v = 9'd158;
         5'd5:    v = 9'd186;
         5'd6:    v = 9'd209;
         5'd7:    v = 9'd229;
         5'd8:    v = 9'd245;
         5'd9:    v = 9'd257;
         5'd10:   v = 9'd267;
         5'd11:   v = 9'd274;
         5'd12:   v = 9'd278;
         5'd13:   v = 9'd281;
         5'd14:   v = 9'd282;
         5'd15:   v = 9'd281;
         5'd16:   v = 9'd279;
         5'd17:   v = 9'd276;
         5'd18:   v = 9'd272;
         5'd19:   v = 9'd269;
         5'd20:   v = 9'd265;
         5'd21:   v = 9'd261;
         5'd22:   v = 9'd259;
         5'd23:   v = 9'd257;
         5'd24:   v = 9'd256;
         default: v = 9'd256;
      endcase
      return v;
   endfunction

endpackage

FILE: hdl/ecu_div_step.sv
// One registered compare-subtract stage of the pipelined restoring divider.
// Uses ecu_pkg for the side-band struct and quotient width.
module ecu_div_step #(
   parameter int RW         = 33,
   parameter int DW         = 31,
   parameter int DOUBLE_REM = 1,
   parameter int DIV_SHIFT  = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  ecu_pkg::side_type             in_side,
   input  logic [RW-1:0]                 in_rem,
   input  logic [DW-1:0]                 in_div,
   input  logic [ecu_pkg::POS_WIDTH-1:0] in_quot,
   output logic                          out_valid,
   output ecu_pkg::side_type             out_side,
   output logic [RW-1:0]                 out_rem,
   output logic [DW-1:0]                 out_div,
   output logic [ecu_pkg::POS_WIDTH-1:0] out_quot
);

   logic [RW-1:0]                 cand;
   logic [RW-1:0]                 dvs;
   logic                          ge;
   logic                          valid_ff;
   ecu_pkg::side_type             side_ff;
   logic [RW-1:0]                 rem_ff, rem_in;
   logic [DW-1:0]                 div_ff;
   logic [ecu_pkg::POS_WIDTH-1:0] quot_ff, quot_in;

   always_comb begin
      if (DOUBLE_REM != 0) begin
         cand = {in_rem[RW-2:0], 1'b0};
      end else begin
         cand = in_rem;
      end
      dvs     = {{(RW-DW){1'b0}}, in_div} << DIV_SHIFT;
      ge      = (cand >= dvs);
      rem_in  = ge ? (cand - dvs) : cand;
      quot_in = {in_quot[ecu_pkg::POS_WIDTH-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      side_ff <= in_side;
      rem_ff  <= rem_in;
      div_ff  <= in_div;
      quot_ff <= quot_in;
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_rem   = rem_ff;
   assign out_div   = div_ff;
   assign out_quot  = quot_ff;

endmodule

FILE: hdl/ecu_shape.sv
// Curve shaping: progress from the spring position, squares and table
// interpolation over three register stages. Uses ecu_pkg.
module ecu_shape (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  ecu_pkg::side_type              in_side,
   input  logic [ecu_pkg::POS_WIDTH-1:0]  in_pos,
   output logic                           out_valid,
   output logic [ecu_pkg::PROG_WIDTH-1:0] out_progress
);

   // stage 1: t = floor(pos/24)
   logic [19:0]       third;
   logic [7:0]        t_in;
   logic              v1_ff;
   ecu_pkg::side_type side1_ff;
   logic [7:0]        t1_ff;
   logic [4:0]        idx1_ff;
   logic [7:0]        frac1_ff;

   // stage 2: products
   logic [8:0]        t_eff, base, a_val, b_val;
   logic signed [9:0] slope;
   logic [16:0]       sq_in;
   logic signed [18:0] sprod_in;
   logic              v2_ff;
   ecu_pkg::side_type side2_ff;
   logic [8:0]        t2_ff, a2_ff;
   logic [16:0]       sq2_ff;
   logic signed [18:0] sprod2_ff;

   // stage 3: result
   logic signed [18:0] adj;
   logic signed [10:0] bump, spring_sum;
   logic [8:0]        prog_in;
   logic              v3_ff;
   logic [8:0]        prog_ff;

   always_comb begin
      third = in_pos[ecu_pkg::POS_WIDTH-1:3] * ecu_pkg::RECIP3;
      t_in  = third[ecu_pkg::RECIP3_SHIFT +: 8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      side1_ff <= in_side;
      t1_ff    <= t_in;
      idx1_ff  <= in_pos[ecu_pkg::POS_WIDTH-1:8];
      frac1_ff <= in_pos[7:0];
   end

   always_comb begin
      if (side1_ff.zero) begin
         t_eff = 9'd0;
      end else if (side1_ff.done) begin
         t_eff = ecu_pkg::PROG_DONE;
      end else begin
         t_eff = {1'b0, t1_ff};
      end
      if (side1_ff.curve == ecu_pkg::CURVE_EASE_OUT) begin
         base = ecu_pkg::PROG_DONE - t_eff;
      end else begin
         base = t_eff;
      end
      sq_in    = base * base;
      a_val    = ecu_pkg::overshoot(idx1_ff);
      b_val    = ecu_pkg::overshoot(idx1_ff + 5'd1);
      slope    = $signed({1'b0, b_val}) - $signed({1'b0, a_val});
      sprod_in = slope * $signed({1'b0, frac1_ff});
   end

   always_ff @(posedge clock) begin
      side2_ff  <= side1_ff;
      t2_ff     <= t_eff;
      a2_ff     <= a_val;
      sq2_ff    <= sq_in;
      sprod2_ff <= sprod_in;
   end

   always_comb begin
      // interpolation step truncates toward zero
      adj        = sprod2_ff[18] ? (sprod2_ff + 19'sd255) : sprod2_ff;
      bump       = adj[18:8];
      spring_sum = $signed({2'b00, a2_ff}) + bump;
      case (side2_ff.curve)
         ecu_pkg::CURVE_LINEAR:   prog_in = t2_ff;
         ecu_pkg::CURVE_EASE_IN:  prog_in = sq2_ff[16:8];
         ecu_pkg::CURVE_EASE_OUT: prog_in = ecu_pkg::PROG_DONE - sq2_ff[16:8];
         ecu_pkg::CURVE_SPRING: begin
            if (side2_ff.zero || side2_ff.done) begin
               prog_in = t2_ff;
            end else begin
               prog_in = spring_sum[8:0];
            end
         end
         default:                 prog_in = t2_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      prog_ff <= prog_in;
   end

   assign out_valid    = v3_ff;
   assign out_progress = prog_ff;

endmodule

FILE: hdl/animation_easing_curve_unit.sv
// Top level of the animation easing curve unit: input stage, divider chain
// and curve shaping. Depends on ecu_pkg, ecu_div_step and ecu_shape.
//
// Usage:
//   Drive req_command, req_elapsed and req_duration and raise start for one
//   cycle per word. busy is always low, so a word is taken at every edge
//   where start is high, one per cycle, with no gaps needed.
//   Each word yields one result word: rsp_valid is high for exactly one
//   cycle with rsp_progress, in 1/256 units (0..282), and results leave in
//   the order the words came in.
//   Throughput: one word per cycle. Between the accepting edge and rsp_valid
//   lie the input stage, one registered compare-subtract stage per bit of
//   the 13-bit spring position and three shaping stages, in that order.
//   Reset (synchronous) clears every valid bit; words in flight are dropped.
//   The receiver has no way to stall; it must take each result word in the
//   cycle the strobe is high.
module animation_easing_curve_unit #(
   parameter int TIME_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [1:0]                     req_command,
   input  logic signed [TIME_WIDTH-1:0]   req_elapsed,
   input  logic signed [TIME_WIDTH-1:0]   req_duration,
   output logic                           rsp_valid,
   output logic [ecu_pkg::PROG_WIDTH-1:0] rsp_progress
);

   localparam int MW = TIME_WIDTH - 1;
   localparam int RW = TIME_WIDTH + 1;

   logic              accept;
   logic              e_pos, d_pos;
   logic [MW-1:0]     e_mag, d_mag;
   ecu_pkg::side_type side_in;
   logic [RW-1:0]     rem_in;

   logic              s0_valid_ff;
   ecu_pkg::side_type s0_side_ff;
   logic [RW-1:0]     s0_rem_ff;
   logic [MW-1:0]     s0_div_ff;

   logic                          valid_chain [ecu_pkg::DIV_STEPS+1];
   ecu_pkg::side_type             side_chain  [ecu_pkg::DIV_STEPS+1];
   logic [ecu_pkg::POS_WIDTH-1:0] quot_chain  [ecu_pkg::DIV_STEPS+1];
   logic [RW-1:0]                 rem_chain   [ecu_pkg::DIV_STEPS];
   logic [MW-1:0]                 div_chain   [ecu_pkg::DIV_STEPS];

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_comb begin
      e_mag         = req_elapsed[MW-1:0];
      d_mag         = req_duration[MW-1:0];
      e_pos         = (req_elapsed != '0) && !req_elapsed[TIME_WIDTH-1];
      d_pos         = (req_duration != '0) && !req_duration[TIME_WIDTH-1];
      side_in.curve = ecu_pkg::curve_type'(req_command);
      side_in.zero  = !(e_pos && d_pos);
      side_in.done  = e_pos && d_pos && (e_mag >= d_mag);
      // 3*e
      rem_in        = {2'b00, e_mag} + {1'b0, e_mag, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s0_side_ff <= side_in;
      s0_rem_ff  <= rem_in;
      s0_div_ff  <= d_mag;
   end

   assign valid_chain[0] = s0_valid_ff;
   assign side_chain[0]  = s0_side_ff;
   assign quot_chain[0]  = '0;
   assign rem_chain[0]   = s0_rem_ff;
   assign div_chain[0]   = s0_div_ff;

   for (genvar k = 0; k < ecu_pkg::DIV_STEPS; k++) begin : g_div
      // first step tests 2d, second d, the rest double then test d
      if (k < ecu_pkg::DIV_STEPS - 1) begin : g_mid
         ecu_div_step #(
            .RW         (RW),
            .DW         (MW),
            .DOUBLE_REM ((k >= 2) ? 1 : 0),
            .DIV_SHIFT  ((k == 0) ? 1 : 0)
         ) u_step (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (valid_chain[k]),
            .in_side   (side_chain[k]),
            .in_rem    (rem_chain[k]),
            .in_div    (div_chain[k]),
            .in_quot   (quot_chain[k]),
            .out_valid (valid_chain[k+1]),
            .out_side  (side_chain[k+1]),
            .out_rem   (rem_chain[k+1]),
            .out_div   (div_chain[k+1]),
            .out_quot  (quot_chain[k+1])
         );
      end else begin : g_last
         ecu_div_step #(
            .RW         (RW),
            .DW         (MW),
            .DOUBLE_REM (1),
            .DIV_SHIFT  (0)
         ) u_step (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (valid_chain[k]),
            .in_side   (side_chain[k]),
            .in_rem    (rem_chain[k]),
            .in_div    (div_chain[k]),
            .in_quot   (quot_chain[k]),
            .out_valid (valid_chain[k+1]),
            .out_side  (side_chain[k+1]),
            .out_rem   (),
            .out_div   (),
            .out_quot  (quot_chain[k+1])
         );
      end
   end

   ecu_shape u_shape (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (valid_chain[ecu_pkg::DIV_STEPS]),
      .in_side      (side_chain[ecu_pkg::DIV_STEPS]),
      .in_pos       (quot_chain[ecu_pkg::DIV_STEPS]),
      .out_valid    (rsp_valid),
      .out_progress (rsp_progress)
   );

endmodule

FILE: hdl/ecu_checker.sv
// Port-level checker for the easing curve unit and its bind statement.
// Depends on ecu_pkg and on the top level animation_easing_curve_unit.
module ecu_checker #(
   parameter int TIME_WIDTH = 32
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic signed [TIME_WIDTH-1:0]   req_elapsed,
   input logic signed [TIME_WIDTH-1:0]   req_duration,
   input logic                           rsp_valid,
   input logic [ecu_pkg::PROG_WIDTH-1:0] rsp_progress
);

   logic                              accept;
   logic                              time_zero;
   logic                              finished;
   logic [ecu_pkg::RSP_LATENCY-1:0]   exp_ff, exp_in;

   assign accept    = start && !busy;
   assign time_zero = ($signed(req_elapsed) <= 0) || ($signed(req_duration) <= 0);
   assign finished  = !time_zero && ($signed(req_elapsed) >= $signed(req_duration));
   assign exp_in    = {exp_ff[ecu_pkg::RSP_LATENCY-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff <= '0;
      end else begin
         exp_ff <= exp_in;
      end
   end

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_progress <= ecu_pkg::PROG_MAX))
      else $error("progress above curve peak");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid == exp_ff[ecu_pkg::RSP_LATENCY-1])
      else $error("result strobe does not match accepted word");

   a_zero: assert property (@(posedge clock) disable iff (reset)
      (accept && time_zero) |-> ##(ecu_pkg::RSP_LATENCY) (rsp_progress == 9'd0))
      else $error("non-positive time did not give zero");

   a_done: assert property (@(posedge clock) disable iff (reset)
      (accept && finished) |-> ##(ecu_pkg::RSP_LATENCY)
         (rsp_progress == ecu_pkg::PROG_DONE))
      else $error("finished animation did not give full progress");

endmodule

bind animation_easing_curve_unit ecu_checker #(
   .TIME_WIDTH (TIME_WIDTH)
) u_ecu_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .req_elapsed  (req_elapsed),
   .req_duration (req_duration),
   .rsp_valid    (rsp_valid),
   .rsp_progress (rsp_progress)
);
